// ----- rtl/detection_tile_nearest_select_assert.svh -----
// Assertion macros for the tile nearest-detection selector.
`ifndef DETECTION_TILE_NEAREST_SELECT_ASSERT_SVH
`define DETECTION_TILE_NEAREST_SELECT_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define DTNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define DTNS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dtns_pkg.sv -----
// Shared constants, types and structs for the tile nearest-detection selector.
`timescale 1ns / 1ps

package dtns_pkg;

    // Mosaic geometry
    localparam int TILES_PER_SIDE = 4;
    localparam int NUM_TILES      = TILES_PER_SIDE * TILES_PER_SIDE;
    localparam int TXY_W          = (TILES_PER_SIDE > 1) ? $clog2(TILES_PER_SIDE) : 1;

    // Field widths
    localparam int TILE_W  = 4;
    localparam int CNT_W   = TILE_W + 1;
    localparam int COORD_W = 16;
    localparam int CODE_W  = 4;
    localparam int SIDE_W  = 12;
    localparam int EDGE_W  = 19;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 31;

    // Stream word widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam logic [SIDE_W-1:0] MOSAIC_SIDE_RST = 12'd640;

    typedef logic [TILE_W-1:0]  t_tile;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [TXY_W-1:0]   t_txy;
    typedef logic [SIDE_W-1:0]  t_side;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [COORD_W-1:0] t_coord;

    // Detection held for the tile walk; edges in 1/32 pixel
    typedef struct packed {
        t_coord                    cx;
        t_coord                    cy;
        logic signed [EDGE_W-1:0]  left;
        logic signed [EDGE_W-1:0]  right;
        logic signed [EDGE_W-1:0]  top;
        logic signed [EDGE_W-1:0]  bottom;
        t_code                     color;
        t_code                     cls;
    } t_box;

    // Per-tile result of the distance unit
    typedef struct packed {
        logic             valid;
        logic             hit;
        t_tile            tile;
        logic [SQ_W-1:0]  sqx;
        logic [SQ_W-1:0]  sqy;
        t_code            color;
        t_code            cls;
    } t_upd;

endpackage

// ----- rtl/dtns_dist_unit.sv -----
// Shared per-tile unit: containment test, center offsets, then squared offsets.
`timescale 1ns / 1ps

module dtns_dist_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_issue,
    input  dtns_pkg::t_tile i_tile,
    input  dtns_pkg::t_side i_side,
    input  dtns_pkg::t_box  i_box,
    output dtns_pkg::t_upd  o_upd,
    output logic            o_busy
);

    typedef struct packed {
        logic                                 hit;
        dtns_pkg::t_tile                      tile;
        logic signed [dtns_pkg::DIFF_W-1:0]   dx;
        logic signed [dtns_pkg::DIFF_W-1:0]   dy;
        dtns_pkg::t_code                      color;
        dtns_pkg::t_code                      cls;
    } t_s1;

    typedef struct packed {
        logic                          hit;
        dtns_pkg::t_tile               tile;
        logic [dtns_pkg::SQ_W-1:0]     sqx;
        logic [dtns_pkg::SQ_W-1:0]     sqy;
        dtns_pkg::t_code               color;
        dtns_pkg::t_code               cls;
    } t_s2;

    dtns_pkg::t_txy                      tx;
    dtns_pkg::t_txy                      ty;
    dtns_pkg::t_side                     tsx;
    dtns_pkg::t_side                     tsy;
    dtns_pkg::t_side                     ex;
    dtns_pkg::t_side                     ey;
    logic signed [dtns_pkg::EDGE_W-1:0]  x0;
    logic signed [dtns_pkg::EDGE_W-1:0]  x1;
    logic signed [dtns_pkg::EDGE_W-1:0]  y0;
    logic signed [dtns_pkg::EDGE_W-1:0]  y1;
    logic [dtns_pkg::COORD_W-1:0]        ccx;
    logic [dtns_pkg::COORD_W-1:0]        ccy;
    t_s1                                 n_s1;
    logic                                r_s1_valid;
    t_s1                                 r_s1;
    logic signed [dtns_pkg::DIFF_W-1:0]  dx1;
    logic signed [dtns_pkg::DIFF_W-1:0]  dy1;
    logic signed [2*dtns_pkg::DIFF_W-1:0] sqx_full;
    logic signed [2*dtns_pkg::DIFF_W-1:0] sqy_full;
    logic                                r_s2_valid;
    t_s2                                 r_s2;

    // Stage 1: tile bounds and center, containment, center offsets
    always_comb begin
        tx  = dtns_pkg::t_txy'(i_tile % dtns_pkg::TILES_PER_SIDE);
        ty  = dtns_pkg::t_txy'(i_tile / dtns_pkg::TILES_PER_SIDE);
        tsx = dtns_pkg::t_side'(tx * i_side);
        tsy = dtns_pkg::t_side'(ty * i_side);
        ex  = dtns_pkg::t_side'(tsx + i_side);
        ey  = dtns_pkg::t_side'(tsy + i_side);
        x0  = {2'b00, tsx, 5'b00000};
        x1  = {2'b00, ex,  5'b00000};
        y0  = {2'b00, tsy, 5'b00000};
        y1  = {2'b00, ey,  5'b00000};
        // center (2t+1)*side*8 in 1/16 pixel
        ccx = {tsx, 4'b0000} + {1'b0, i_side, 3'b000};
        ccy = {tsy, 4'b0000} + {1'b0, i_side, 3'b000};
        n_s1.hit   = (i_box.left >= x0) && (i_box.right <= x1) &&
                     (i_box.top >= y0) && (i_box.bottom <= y1);
        n_s1.tile  = i_tile;
        n_s1.dx    = signed'({1'b0, i_box.cx}) - signed'({1'b0, ccx});
        n_s1.dy    = signed'({1'b0, i_box.cy}) - signed'({1'b0, ccy});
        n_s1.color = i_box.color;
        n_s1.cls   = i_box.cls;
    end

    // Stage 2: squares of the offsets
    assign dx1      = r_s1.dx;
    assign dy1      = r_s1.dy;
    assign sqx_full = dx1 * dx1;
    assign sqy_full = dy1 * dy1;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        r_s1       <= n_s1;
        r_s2.hit   <= r_s1.hit;
        r_s2.tile  <= r_s1.tile;
        r_s2.sqx   <= sqx_full[dtns_pkg::SQ_W-1:0];
        r_s2.sqy   <= sqy_full[dtns_pkg::SQ_W-1:0];
        r_s2.color <= r_s1.color;
        r_s2.cls   <= r_s1.cls;
    end

    assign o_upd.valid = r_s2_valid;
    assign o_upd.hit   = r_s2.hit;
    assign o_upd.tile  = r_s2.tile;
    assign o_upd.sqx   = r_s2.sqx;
    assign o_upd.sqy   = r_s2.sqy;
    assign o_upd.color = r_s2.color;
    assign o_upd.cls   = r_s2.cls;
    assign o_busy      = r_s1_valid | r_s2_valid;

endmodule

// ----- rtl/dtns_tile_store.sv -----
// Per-tile best-distance store with compare-and-update and result read.
`timescale 1ns / 1ps

module dtns_tile_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dtns_pkg::t_upd  i_upd,
    input  logic            i_clear,
    input  dtns_pkg::t_tile i_rd_idx,
    output logic            o_rd_found,
    output dtns_pkg::t_code o_rd_color,
    output dtns_pkg::t_code o_rd_class
);

    logic [dtns_pkg::NUM_TILES-1:0] r_found;
    logic [dtns_pkg::DIST_W-1:0]    r_best  [dtns_pkg::NUM_TILES];
    dtns_pkg::t_code                r_color [dtns_pkg::NUM_TILES];
    dtns_pkg::t_code                r_class [dtns_pkg::NUM_TILES];

    logic [dtns_pkg::SQ_W:0]        sum_sq;
    logic                           take;

    // Sum of squares against the stored best; first contained box always wins
    assign sum_sq = {1'b0, i_upd.sqx} + {1'b0, i_upd.sqy};
    assign take = i_upd.valid && i_upd.hit &&
                  (!r_found[i_upd.tile] || (sum_sq < {2'b00, r_best[i_upd.tile]}));

    // Found flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= '0;
        end else if (i_clear) begin
            r_found <= '0;
        end else if (take) begin
            r_found[i_upd.tile] <= 1'b1;
        end
    end

    // Best distance and codes
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best[i_upd.tile]  <= sum_sq[dtns_pkg::DIST_W-1:0];
            r_color[i_upd.tile] <= i_upd.color;
            r_class[i_upd.tile] <= i_upd.cls;
        end
    end

    // Result read, codes forced to zero for an empty tile
    assign o_rd_found = r_found[i_rd_idx];
    assign o_rd_color = r_found[i_rd_idx] ? r_color[i_rd_idx] : '0;
    assign o_rd_class = r_found[i_rd_idx] ? r_class[i_rd_idx] : '0;

endmodule

// ----- rtl/detection_tile_nearest_select.sv -----
// Top level: stream ports, mosaic side register, tile-walk sequencer, result output.
`timescale 1ns / 1ps

// Keeps, for each tile of a 4x4 mosaic, the fully contained detection nearest
// to the tile center, and reports one word per tile in use at the end of the
// mosaic. A detection word is accepted, then the sequencer walks all 16 tiles
// through one shared distance unit, one tile per cycle, and waits while the
// unit's two register stages drain into the tile store; s_tready is low
// meanwhile. A word without a detection starts no tile walk. The end-of-mosaic
// word then sends one result per tile in use, one per cycle while m_tready is
// high, with s_tready low until the last is loaded, and the tile state is
// cleared with the last of them. mosaic_side may be written only while idle.

module detection_tile_nearest_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // mosaic_side
    input  logic                              i_cfg_we,
    input  logic [dtns_pkg::SIDE_W-1:0]       i_cfg_data,
    // detection words
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // box_cx, box_cy, box_w, box_h, box_color, box_class, tiles_in_use, pad
    input  logic [dtns_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                              i_s_tlast,   // end_of_mosaic
    input  logic                              i_s_tuser,   // has_box
    // tile results
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tile_index, chosen_color, chosen_class, pad
    output logic [dtns_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tlast,   // last_tile
    output logic                              o_m_tuser    // found
);

`include "detection_tile_nearest_select_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state                 r_state;
    dtns_pkg::t_side        r_mosaic_side;
    dtns_pkg::t_box         r_box;
    dtns_pkg::t_cnt         r_tile;
    dtns_pkg::t_cnt         r_count;
    logic                   r_end;
    logic                   r_out_valid;
    dtns_pkg::t_tile        r_out_tile;
    logic                   r_out_found;
    dtns_pkg::t_code        r_out_color;
    dtns_pkg::t_code        r_out_class;
    logic                   r_out_last;

    dtns_pkg::t_coord       in_cx;
    dtns_pkg::t_coord       in_cy;
    dtns_pkg::t_coord       in_w;
    dtns_pkg::t_coord       in_h;
    logic [4:0]             in_tiles;
    dtns_pkg::t_cnt         sat_count;
    dtns_pkg::t_box         n_box;
    logic                   s_acc;
    logic                   emit_load;
    logic                   emit_last;
    logic                   clr_tiles;
    dtns_pkg::t_side        side;
    dtns_pkg::t_upd         upd;
    logic                   busy;
    logic                   rd_found;
    dtns_pkg::t_code        rd_color;
    dtns_pkg::t_code        rd_class;

    // Input word unpacking
    assign in_cx    = i_s_tdata[15:0];
    assign in_cy    = i_s_tdata[31:16];
    assign in_w     = i_s_tdata[47:32];
    assign in_h     = i_s_tdata[63:48];
    assign in_tiles = i_s_tdata[76:72];
    assign sat_count = (in_tiles > dtns_pkg::t_cnt'(dtns_pkg::NUM_TILES)) ?
                       dtns_pkg::t_cnt'(dtns_pkg::NUM_TILES) : dtns_pkg::t_cnt'(in_tiles);

    // Box edges in 1/32 pixel: 2*center -/+ size
    always_comb begin
        n_box.cx     = in_cx;
        n_box.cy     = in_cy;
        n_box.left   = signed'({2'b00, in_cx, 1'b0}) - signed'({3'b000, in_w});
        n_box.right  = signed'({2'b00, in_cx, 1'b0}) + signed'({3'b000, in_w});
        n_box.top    = signed'({2'b00, in_cy, 1'b0}) - signed'({3'b000, in_h});
        n_box.bottom = signed'({2'b00, in_cy, 1'b0}) + signed'({3'b000, in_h});
        n_box.color  = i_s_tdata[67:64];
        n_box.cls    = i_s_tdata[71:68];
    end

    assign side = dtns_pkg::t_side'(r_mosaic_side / dtns_pkg::TILES_PER_SIDE);

    // Handshake and sequencing strobes
    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign emit_load  = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);
    assign emit_last  = (dtns_pkg::t_cnt'(r_tile + 1'b1) == r_count);
    assign clr_tiles  = (emit_load && emit_last) ||
                        (s_acc && !i_s_tuser && i_s_tlast && (sat_count == '0)) ||
                        ((r_state == S_DRAIN) && !busy && r_end && (r_count == '0));

    // Mosaic side register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mosaic_side <= dtns_pkg::MOSAIC_SIDE_RST;
        end else if (i_cfg_we) begin
            r_mosaic_side <= i_cfg_data;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tile      <= '0;
            r_count     <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_box   <= n_box;
                        r_count <= sat_count;
                        r_end   <= i_s_tlast;
                        r_tile  <= '0;
                        if (i_s_tuser) begin
                            r_state <= S_SCAN;
                        end else if (i_s_tlast && (sat_count != '0)) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_SCAN: begin
                    r_tile <= dtns_pkg::t_cnt'(r_tile + 1'b1);
                    if (r_tile == dtns_pkg::t_cnt'(dtns_pkg::NUM_TILES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!busy) begin
                        r_tile <= '0;
                        if (r_end && (r_count != '0)) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_load) begin
                        r_tile <= dtns_pkg::t_cnt'(r_tile + 1'b1);
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // result word
            if (emit_load) begin
                r_out_valid <= 1'b1;
                r_out_tile  <= r_tile[dtns_pkg::TILE_W-1:0];
                r_out_found <= rd_found;
                r_out_color <= rd_color;
                r_out_class <= rd_class;
                r_out_last  <= emit_last;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shared distance unit, one tile per cycle
    dtns_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (r_state == S_SCAN),
        .i_tile  (r_tile[dtns_pkg::TILE_W-1:0]),
        .i_side  (side),
        .i_box   (r_box),
        .o_upd   (upd),
        .o_busy  (busy)
    );

    // Per-tile best store
    dtns_tile_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (upd),
        .i_clear    (clr_tiles),
        .i_rd_idx   (r_tile[dtns_pkg::TILE_W-1:0]),
        .o_rd_found (rd_found),
        .o_rd_color (rd_color),
        .o_rd_class (rd_class)
    );

    // Output word packing
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_class, r_out_color, r_out_tile};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_found;

    // Checks
    `DTNS_ASSERT_NEXT(a_box_starts_scan, s_acc && i_s_tuser, r_state == S_SCAN,
        "detection word did not start a tile walk")
    `DTNS_ASSERT_SAME(a_emit_after_drain, r_state == S_EMIT, !busy,
        "results sent while distance unit still busy")
    `DTNS_ASSERT_SAME(a_emit_in_range, r_state == S_EMIT, r_tile < r_count,
        "result tile beyond tiles in use")
    `DTNS_ASSERT_NEXT(a_last_goes_idle, emit_load && emit_last,
        (r_state == S_IDLE) && o_m_tvalid && o_m_tlast,
        "last result did not end the mosaic")

endmodule
